// ----- sv/rxd_pkg.sv -----
`timescale 1ns / 1ps

package rxd_pkg;

    localparam int PIXELS_PER_RESULT = 4;
    localparam int PIX_IDX_W         = $clog2(PIXELS_PER_RESULT);
    localparam int MAX_HEIGHT        = 1024;
    localparam int CFG_W             = 11;
    localparam int CFG_ADDR_W        = 2;

    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_TRANS_ENABLE = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_TRANS_INDEX  = 2'd3;

    localparam logic [7:0] VALUE_MAX  = 8'h0f;
    localparam logic [7:0] RUN_OFFSET = 8'h0e;
    localparam logic [7:0] ALPHA_FULL = 8'hff;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [31:0] pixel0_rgba;
        logic [31:0] pixel1_rgba;
        logic [31:0] pixel2_rgba;
        logic [31:0] pixel3_rgba;
        logic [2:0]  pixel_count;
        logic        run_end;
        logic        image_done;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_WRITE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic accept;
        logic rd;
        logic px;
        logic emit;
        logic fail;
    } cmd_t;

    typedef struct packed {
        logic work_valid;
        logic pre_fail;
        logic need_emit;
        logic out_free;
    } sts_t;

    function automatic logic [23:0] palette_rgb(input logic [3:0] idx);
        logic [23:0] rgb;
        unique case (idx)
            4'd0:    rgb = 24'h000000;
            4'd1:    rgb = 24'ha70b40;
            4'd2:    rgb = 24'h406300;
            4'd3:    rgb = 24'he66f00;
            4'd4:    rgb = 24'h007440;
            4'd5:    rgb = 24'h808080;
            4'd6:    rgb = 24'h19d700;
            4'd7:    rgb = 24'hbfe308;
            4'd8:    rgb = 24'h401cf7;
            4'd9:    rgb = 24'he628ff;
            4'd10:   rgb = 24'h808080;
            4'd11:   rgb = 24'hff8bbf;
            4'd12:   rgb = 24'h1990ff;
            4'd13:   rgb = 24'hbf9cff;
            4'd14:   rgb = 24'h58f4bf;
            default: rgb = 24'hffffff;
        endcase
        return rgb;
    endfunction

endpackage

// ----- sv/rxd_ctrl.sv -----
`timescale 1ns / 1ps

module rxd_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  rxd_pkg::sts_t sts,
    output rxd_pkg::cmd_t cmd
);
    import rxd_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                if (!sts.work_valid) begin
                    state_next = ST_IDLE;
                end else if (sts.pre_fail) begin
                    cmd.fail   = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    cmd.rd     = 1'b1;
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                cmd.px     = 1'b1;
                state_next = sts.need_emit ? ST_EMIT : ST_READ;
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = sts.work_valid ? ST_READ : ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Work left over from an item must never be visible while a new item can enter.
    a_idle_no_work: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !sts.work_valid)
        else $error("segment work pending while idle");

endmodule

// ----- sv/rxd_dp.sv -----
`timescale 1ns / 1ps

module rxd_dp #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [rxd_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [rxd_pkg::CFG_W-1:0]         cfg_wdata,
    input  rxd_pkg::in_item_t                 s_item,
    input  logic                              m_ready,
    output logic                              m_valid,
    output rxd_pkg::out_item_t                m_item,
    input  rxd_pkg::cmd_t                     cmd,
    output rxd_pkg::sts_t                     sts
);
    import rxd_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = CW + 1;
    localparam int HW = $clog2(MAX_HEIGHT) + 1;
    localparam int PW = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int NP = PIXELS_PER_RESULT;

    logic [CFG_W-1:0] width_cfg_reg;
    logic [CFG_W-1:0] height_cfg_reg;
    logic             trans_en_reg;
    logic [3:0]       trans_idx_reg;

    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;
    logic [PW-1:0] total_reg;

    logic          pending_valid_reg;
    logic [3:0]    pending_value_reg;
    logic          finished_reg;
    logic [CW-1:0] col_reg;
    logic [PW-1:0] pw_reg;

    logic          a_valid_reg;
    logic [3:0]    a_val_reg;
    logic [7:0]    a_len_reg;
    logic          b_valid_reg;
    logic [3:0]    b_val_reg;

    logic [3:0]    row_mem [MAX_WIDTH];
    logic [3:0]    rdata_reg;

    logic [31:0]   pack_reg [NP];
    logic [2:0]    pack_cnt_reg;
    logic          pack_end_reg;
    logic          pack_done_reg;

    logic          m_valid_reg;
    out_item_t     m_item_reg;

    logic [CW-1:0] col_eff;
    logic [WW-1:0] col_inc;
    logic [CW-1:0] col_next;
    logic [PW:0]   pw_inc;
    logic          xor_en;
    logic [3:0]    px;
    logic [31:0]   rgba;
    logic          done;
    logic          seg_last;
    logic          last_pix;

    logic          acc_pv;
    logic [3:0]    acc_pval;
    logic          acc_fin;
    logic          acc_run;
    logic          acc_flush;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_cfg_reg  <= CFG_W'(1);
            height_cfg_reg <= CFG_W'(1);
            trans_en_reg   <= 1'b0;
            trans_idx_reg  <= 4'd0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_IMAGE_WIDTH:  width_cfg_reg  <= cfg_wdata;
                REG_IMAGE_HEIGHT: height_cfg_reg <= cfg_wdata;
                REG_TRANS_ENABLE: trans_en_reg   <= cfg_wdata[0];
                REG_TRANS_INDEX:  trans_idx_reg  <= cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (width_cfg_reg == '0) begin
            w_eff = WW'(1);
        end else if (32'(width_cfg_reg) > 32'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(width_cfg_reg);
        end
        if (height_cfg_reg == '0) begin
            h_eff = HW'(1);
        end else if (32'(height_cfg_reg) > 32'(MAX_HEIGHT)) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = HW'(height_cfg_reg);
        end
    end

    always_ff @(posedge aclk) begin
        total_reg <= PW'(w_eff) * PW'(h_eff);
    end

    always_comb begin
        col_eff  = ({1'b0, col_reg} >= w_eff) ? '0 : col_reg;
        col_inc  = {1'b0, col_eff} + WW'(1);
        col_next = (col_inc >= w_eff) ? '0 : col_inc[CW-1:0];
        pw_inc   = {1'b0, pw_reg} + (PW+1)'(1);
        xor_en   = pw_reg >= PW'(w_eff);
        px       = a_val_reg ^ (xor_en ? rdata_reg : 4'd0);
        rgba     = (trans_en_reg && (px == trans_idx_reg)) ? 32'd0
                                                           : {palette_rgb(px), ALPHA_FULL};
        done     = pw_inc >= {1'b0, total_reg};
        seg_last = (a_len_reg == 8'd1);
        last_pix = done || (seg_last && !b_valid_reg);
    end

    always_comb begin
        acc_pv    = s_item.first_byte ? 1'b0 : pending_valid_reg;
        acc_pval  = s_item.first_byte ? 4'd0 : pending_value_reg;
        acc_fin   = s_item.first_byte ? 1'b0 : finished_reg;
        acc_run   = acc_pv && (s_item.data_byte > VALUE_MAX);
        acc_flush = s_item.last_byte && !acc_run;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_valid_reg <= 1'b0;
            pending_value_reg <= 4'd0;
            finished_reg      <= 1'b0;
            col_reg           <= '0;
            pw_reg            <= '0;
            a_valid_reg       <= 1'b0;
            b_valid_reg       <= 1'b0;
        end else if (cmd.accept) begin
            if (s_item.first_byte) begin
                col_reg      <= '0;
                pw_reg       <= '0;
                finished_reg <= 1'b0;
            end
            if (acc_fin) begin
                a_valid_reg <= 1'b0;
                b_valid_reg <= 1'b0;
            end else begin
                pending_valid_reg <= !acc_run && !acc_flush;
                pending_value_reg <= acc_run ? acc_pval : s_item.data_byte[3:0];
                if (acc_pv) begin
                    a_valid_reg <= 1'b1;
                    a_val_reg   <= acc_pval;
                    a_len_reg   <= acc_run ? (s_item.data_byte - RUN_OFFSET) : 8'd1;
                    b_valid_reg <= acc_flush;
                    b_val_reg   <= s_item.data_byte[3:0];
                end else begin
                    a_valid_reg <= acc_flush;
                    a_val_reg   <= s_item.data_byte[3:0];
                    a_len_reg   <= 8'd1;
                    b_valid_reg <= 1'b0;
                end
            end
        end else if (cmd.fail) begin
            finished_reg      <= 1'b1;
            pending_valid_reg <= 1'b0;
            a_valid_reg       <= 1'b0;
            b_valid_reg       <= 1'b0;
        end else if (cmd.px) begin
            col_reg <= col_next;
            pw_reg  <= pw_inc[PW-1:0];
            if (done) begin
                finished_reg      <= 1'b1;
                pending_valid_reg <= 1'b0;
                a_valid_reg       <= 1'b0;
                b_valid_reg       <= 1'b0;
            end else if (seg_last) begin
                if (b_valid_reg) begin
                    a_val_reg   <= b_val_reg;
                    a_len_reg   <= 8'd1;
                    b_valid_reg <= 1'b0;
                end else begin
                    a_valid_reg <= 1'b0;
                end
            end else begin
                a_len_reg <= a_len_reg - 8'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.px) begin
            row_mem[col_eff] <= px;
        end
        if (cmd.rd) begin
            rdata_reg <= row_mem[col_eff];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NP; i++) begin
                pack_reg[i] <= 32'd0;
            end
            pack_cnt_reg  <= 3'd0;
            pack_end_reg  <= 1'b0;
            pack_done_reg <= 1'b0;
        end else if (cmd.emit) begin
            for (int i = 0; i < NP; i++) begin
                pack_reg[i] <= 32'd0;
            end
            pack_cnt_reg  <= 3'd0;
            pack_end_reg  <= 1'b0;
            pack_done_reg <= 1'b0;
        end else if (cmd.px) begin
            pack_reg[pack_cnt_reg[PIX_IDX_W-1:0]] <= rgba;
            pack_cnt_reg  <= pack_cnt_reg + 3'd1;
            pack_end_reg  <= last_pix;
            pack_done_reg <= done;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_item_reg.pixel0_rgba <= pack_reg[0];
            m_item_reg.pixel1_rgba <= pack_reg[1];
            m_item_reg.pixel2_rgba <= pack_reg[2];
            m_item_reg.pixel3_rgba <= pack_reg[3];
            m_item_reg.pixel_count <= pack_cnt_reg;
            m_item_reg.run_end     <= pack_end_reg;
            m_item_reg.image_done  <= pack_done_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    assign sts.work_valid = a_valid_reg;
    assign sts.pre_fail   = pw_reg >= total_reg;
    assign sts.need_emit  = last_pix || (pack_cnt_reg == 3'(NP - 1));
    assign sts.out_free   = !m_valid_reg || m_ready;

    a_emit_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (pack_cnt_reg != 3'd0) && (pack_cnt_reg <= 3'(NP)))
        else $error("item emitted with an invalid pixel count");

    a_done_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.px && done) |=> pack_end_reg && finished_reg && !a_valid_reg)
        else $error("image end did not close the run");

    a_emit_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !cmd.emit)
        else $error("output item overwritten before it was taken");

endmodule

// ----- sv/rle_xor_image_decoder_top.sv -----
`timescale 1ns / 1ps
// Channel  | Ports                          | Item
// ---------+--------------------------------+-----------------------------------
// input    | s_valid, s_ready, s_item       | one payload byte with first/last
// output   | m_valid, m_ready, m_item       | up to four RGBA pixels and flags
// config   | cfg_wr_en, cfg_addr, cfg_wdata | one register write, no wait
//
// Each pixel is read from the row memory, then XORed, mapped through the palette and written back,
// and each filled item then goes on to the output register in a step of its own.
// A byte that makes no pixel goes through the read state straight back to idle.
// A new byte is taken once the previous one has handed its last item to the output register.
// Reset is synchronous, active low; the row memory is not cleared.
// A stalled output holds the decoder only when a second item is ready to go out.

module rle_xor_image_decoder_top #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [rxd_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [rxd_pkg::CFG_W-1:0]         cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  rxd_pkg::in_item_t                 s_item,
    output logic                              m_valid,
    input  logic                              m_ready,
    output rxd_pkg::out_item_t                m_item
);
    import rxd_pkg::*;

    cmd_t cmd;
    sts_t sts;

    rxd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    rxd_dp #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_item    (s_item),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_item    (m_item),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

// ----- sim/rle_xor_image_decoder_top_tb.sv -----
`timescale 1ns / 1ps

module rle_xor_image_decoder_top_tb;

    import rxd_pkg::*;

    localparam int          ROW_CAPACITY = 1024;
    localparam int          DRAIN_CYCLES = 32;
    localparam int unsigned CYCLE_LIMIT  = 3000000;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_W-1:0]      cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    in_item_t              s_item;
    logic                  m_valid;
    logic                  m_ready;
    out_item_t             m_item;

    // Register copies and decoder state of the predictor.
    logic [10:0] width_reg     = 11'd1;
    logic [10:0] height_reg    = 11'd1;
    logic        trans_en_reg  = 1'b0;
    logic [3:0]  trans_idx_reg = 4'd0;
    logic        pend_valid    = 1'b0;
    logic [3:0]  pend_val      = 4'd0;
    logic [3:0]  row_mem [ROW_CAPACITY];
    int unsigned col_pos       = 0;
    int unsigned px_done       = 0;
    logic        image_closed  = 1'b0;

    logic [23:0] colour_lut [16] = '{
        24'h000000, 24'ha70b40, 24'h406300, 24'he66f00,
        24'h007440, 24'h808080, 24'h19d700, 24'hbfe308,
        24'h401cf7, 24'he628ff, 24'h808080, 24'hff8bbf,
        24'h1990ff, 24'hbf9cff, 24'h58f4bf, 24'hffffff
    };

    out_item_t   expected_pixels [$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    int          tx_gap_max     = 14;
    int          rx_stall_max   = 14;
    int          rx_hold_cycles = 0;

    rle_xor_image_decoder_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic logic [31:0] rgba_of(input logic [3:0] idx);
        if (trans_en_reg && idx == trans_idx_reg) begin
            return 32'h0;
        end
        return {colour_lut[idx], ALPHA_FULL};
    endfunction

    task automatic decode_byte(input in_item_t it);
        logic [3:0]  seg_val [2];
        int unsigned seg_len [2];
        int unsigned nseg;
        int unsigned w;
        int unsigned h;
        int unsigned total;
        int unsigned fill;
        logic [3:0]  px;
        logic [31:0] rgba;
        out_item_t   cur;
        out_item_t   batch [$];
        if (it.first_byte) begin
            pend_valid   = 1'b0;
            pend_val     = 4'd0;
            col_pos      = 0;
            px_done      = 0;
            image_closed = 1'b0;
        end
        if (image_closed) begin
            return;
        end
        nseg = 0;
        if (pend_valid && it.data_byte > VALUE_MAX) begin
            seg_val[0] = pend_val;
            seg_len[0] = it.data_byte - RUN_OFFSET;
            nseg       = 1;
            pend_valid = 1'b0;
        end else begin
            if (pend_valid) begin
                seg_val[0] = pend_val;
                seg_len[0] = 1;
                nseg       = 1;
            end
            pend_val   = it.data_byte[3:0];
            pend_valid = 1'b1;
        end
        if (it.last_byte && pend_valid) begin
            seg_val[nseg] = pend_val;
            seg_len[nseg] = 1;
            nseg++;
            pend_valid = 1'b0;
        end
        w = (width_reg == 0) ? 1 : (width_reg > ROW_CAPACITY) ? ROW_CAPACITY : width_reg;
        h = (height_reg == 0) ? 1 : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
        total = w * h;
        fill  = 0;
        cur   = '0;
        for (int s = 0; s < nseg && !image_closed; s++) begin
            for (int unsigned r = 0; r < seg_len[s]; r++) begin
                if (px_done >= total) begin
                    image_closed = 1'b1;
                    pend_valid   = 1'b0;
                    break;
                end
                if (col_pos >= w) begin
                    col_pos = 0;
                end
                px = seg_val[s];
                if (px_done >= w) begin
                    px = px ^ row_mem[col_pos];
                end
                row_mem[col_pos] = px;
                col_pos++;
                if (col_pos >= w) begin
                    col_pos = 0;
                end
                px_done++;
                rgba = rgba_of(px);
                case (fill)
                    0: begin
                        cur = '0;
                        cur.pixel0_rgba = rgba;
                    end
                    1: cur.pixel1_rgba = rgba;
                    2: cur.pixel2_rgba = rgba;
                    default: cur.pixel3_rgba = rgba;
                endcase
                fill++;
                cur.pixel_count = 3'(fill);
                if (px_done >= total) begin
                    cur.image_done = 1'b1;
                    image_closed   = 1'b1;
                    pend_valid     = 1'b0;
                end
                if (fill == PIXELS_PER_RESULT) begin
                    batch.push_back(cur);
                    fill = 0;
                end
                if (image_closed) begin
                    break;
                end
            end
        end
        if (fill > 0) begin
            batch.push_back(cur);
        end
        foreach (batch[i]) begin
            cur = batch[i];
            cur.run_end = (i == batch.size() - 1);
            expected_pixels.push_back(cur);
        end
    endtask

    function automatic in_item_t payload(input logic [7:0] data, input logic f, input logic l);
        in_item_t it;
        it.data_byte  = data;
        it.first_byte = f;
        it.last_byte  = l;
        return it;
    endfunction

    // Mostly value/count pairs that walk through whole images, with some raw noise.
    function automatic in_item_t next_stream_byte(input bit start);
        in_item_t it;
        it = '0;
        if ($urandom_range(0, 9) == 0) begin
            it.data_byte  = 8'($urandom_range(0, 255));
            it.first_byte = ($urandom_range(0, 7) == 0);
            it.last_byte  = ($urandom_range(0, 7) == 0);
        end else begin
            it.first_byte = start || image_closed;
            if (pend_valid && !it.first_byte && $urandom_range(0, 4) < 3) begin
                if ($urandom_range(0, 29) == 0) begin
                    it.data_byte = 8'hff;
                end else begin
                    it.data_byte = 8'($urandom_range(16, 40));
                end
            end else begin
                it.data_byte = 8'($urandom_range(0, 15));
            end
            it.last_byte = ($urandom_range(0, 19) == 0);
        end
        if (start) begin
            it.first_byte = 1'b1;
        end
        return it;
    endfunction

    task automatic send_byte(input in_item_t it);
        int unsigned gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (!s_ready);
        decode_byte(it);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic configure(input int unsigned w, input int unsigned h,
                             input int unsigned te, input int unsigned ti);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= REG_IMAGE_WIDTH;
        cfg_wdata <= CFG_W'(w);
        @(posedge aclk);
        cfg_addr  <= REG_IMAGE_HEIGHT;
        cfg_wdata <= CFG_W'(h);
        @(posedge aclk);
        cfg_addr  <= REG_TRANS_ENABLE;
        cfg_wdata <= CFG_W'(te);
        @(posedge aclk);
        cfg_addr  <= REG_TRANS_INDEX;
        cfg_wdata <= CFG_W'(ti);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        width_reg     = 11'(w);
        height_reg    = 11'(h);
        trans_en_reg  = 1'(te);
        trans_idx_reg = 4'(ti);
    endtask

    task automatic test_reset_values();
        send_byte(payload(8'h05, 1'b1, 1'b1));
        send_byte(payload(8'hff, 1'b0, 1'b0));
        send_byte(payload(8'h13, 1'b1, 1'b0));
        send_byte(payload(8'h10, 1'b0, 1'b0));
        send_byte(payload(8'h00, 1'b1, 1'b0));
        send_byte(payload(8'h0f, 1'b0, 1'b0));
    endtask

    task automatic test_decode_rules();
        wait_idle();
        configure(3, 3, 1, 9);
        send_byte(payload(8'h20, 1'b1, 1'b0));
        send_byte(payload(8'h09, 1'b0, 1'b0));
        send_byte(payload(8'h12, 1'b0, 1'b0));
        send_byte(payload(8'h04, 1'b0, 1'b0));
        send_byte(payload(8'h07, 1'b1, 1'b0));
        send_byte(payload(8'h0e, 1'b0, 1'b1));
        send_byte(payload(8'h0f, 1'b0, 1'b0));
        send_byte(payload(8'hff, 1'b0, 1'b0));
        send_byte(payload(8'h01, 1'b0, 1'b0));
    endtask

    task automatic test_size_limits();
        wait_idle();
        configure(0, 0, 1, 0);
        send_byte(payload(8'h0a, 1'b1, 1'b1));
        send_byte(payload(8'h00, 1'b1, 1'b1));
        wait_idle();
        configure(2047, 2047, 0, 0);
        send_byte(payload(8'h0b, 1'b1, 1'b0));
        send_byte(payload(8'hff, 1'b0, 1'b0));
        for (int k = 0; k < 4; k++) begin
            send_byte(payload(8'($urandom_range(0, 15)), 1'b0, 1'b0));
            send_byte(payload(8'hff, 1'b0, 1'b0));
        end
    endtask

    task automatic test_backpressure();
        wait_idle();
        configure(8, 64, 1, 15);
        tx_gap_max     = 0;
        rx_stall_max   = 0;
        rx_hold_cycles = 400;
        for (int n = 0; n < 40; n++) begin
            send_byte(next_stream_byte(n == 0));
        end
        wait_idle();
        tx_gap_max   = 14;
        rx_stall_max = 14;
    endtask

    task automatic test_random_images();
        int unsigned w;
        for (int ph = 0; ph < 8; ph++) begin
            wait_idle();
            case ($urandom_range(0, 3))
                0:       w = 1;
                3:       w = $urandom_range(17, 64);
                default: w = $urandom_range(2, 16);
            endcase
            configure(w, $urandom_range(1, 6), $urandom_range(0, 1), $urandom_range(0, 15));
            tx_gap_max   = (ph % 3 == 0) ? 0 : 14;
            rx_stall_max = (ph % 4 == 1) ? 0 : 14;
            for (int n = 0; n < 38; n++) begin
                send_byte(next_stream_byte(n == 0));
            end
        end
    endtask

    initial begin : stimulus
        aresetn   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_addr  <= '0;
        cfg_wdata <= '0;
        s_valid   <= 1'b0;
        s_item    <= '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_values();
        test_decode_rules();
        test_size_limits();
        test_backpressure();
        test_random_images();
        wait_idle();
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin : result_sink
        int unsigned stall;
        m_ready <= 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if (rx_hold_cycles > 0) begin
                m_ready <= 1'b0;
                repeat (rx_hold_cycles) @(posedge aclk);
                rx_hold_cycles = 0;
            end
            stall = $urandom_range(0, rx_stall_max);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
                $display("mismatch in %s: expected %h, got %h", name, want, got);
            end
        end
    endfunction

    always @(posedge aclk) begin : pixel_checker
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_pixels.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("unexpected item: expected none, got %h", m_item);
                end
            end else begin
                want = expected_pixels.pop_front();
                check_field("pixel0_rgba", want.pixel0_rgba, m_item.pixel0_rgba);
                check_field("pixel1_rgba", want.pixel1_rgba, m_item.pixel1_rgba);
                check_field("pixel2_rgba", want.pixel2_rgba, m_item.pixel2_rgba);
                check_field("pixel3_rgba", want.pixel3_rgba, m_item.pixel3_rgba);
                check_field("pixel_count", 32'(want.pixel_count), 32'(m_item.pixel_count));
                check_field("run_end", 32'(want.run_end), 32'(m_item.run_end));
                check_field("image_done", 32'(want.image_done), 32'(m_item.image_done));
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/rxd_pkg.sv
sv/rxd_ctrl.sv
sv/rxd_dp.sv
sv/rle_xor_image_decoder_top.sv
sim/rle_xor_image_decoder_top_tb.sv
